### hw/rtl/xpsd_pkg.sv
package xpsd_pkg;

  localparam int TableDepth = 256;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;

  localparam logic [1:0] OpDefine = 2'd0;
  localparam logic [1:0] OpPixel = 2'd1;
  localparam logic [1:0] OpStart = 2'd2;

  localparam logic [1:0] RegCpp = 2'd0;
  localparam logic [1:0] RegWidth = 2'd1;

  typedef struct packed {
    logic [1:0] operation;
    logic [31:0] symbol;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic is_none;
    logic [7:0] pixel_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] palette_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic found;
    logic row_end;
  } out_item_t;

  // Work handed from the front end to the lookup engine.
  typedef struct packed {
    logic is_start;
    logic is_define;
    logic [31:0] symbol;
    logic [23:0] color;
    logic [31:0] mask;
    logic row_end;
  } job_t;

endpackage

### hw/rtl/xpsd_stream_if.sv
interface xpsd_stream_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/xpsd_front.sv
module xpsd_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  xpsd_pkg::in_item_t in_item,
  input  logic [2:0] chars_per_pixel,
  input  logic [15:0] image_width,
  output logic job_valid,
  input  logic job_ready,
  output xpsd_pkg::job_t job
);
  import xpsd_pkg::*;

  logic [23:0] char_buffer;
  logic [1:0] char_position;
  logic [15:0] column_count;
  logic [2:0] cpp;
  logic [31:0] sym;
  logic [15:0] width;
  logic take;
  logic done;

  // Queue of two jobs between the front end and the lookup engine.
  job_t q [2];
  logic [1:0] q_count;
  logic q_rd;
  logic push;

  always_comb begin
    cpp = chars_per_pixel;
    if (cpp == 3'd0) cpp = 3'd1;
    if (cpp > 3'd4) cpp = 3'd4;
    sym = {8'd0, char_buffer} | ({24'd0, in_item.pixel_char} << {char_position, 3'd0});
    done = ({1'b0, char_position} + 3'd1) >= cpp;
    width = (image_width == 16'd0) ? 16'd1 : image_width;
  end

  assign in_ready = (q_count != 2'd2);
  assign take = in_valid && in_ready;
  assign q_rd = job_valid && job_ready;
  assign job_valid = (q_count != 2'd0);
  assign job = q[0];

  job_t nj;
  always_comb begin
    nj.is_start = (in_item.operation == OpStart);
    nj.is_define = (in_item.operation == OpDefine);
    nj.symbol = (in_item.operation == OpDefine) ? in_item.symbol : sym;
    nj.color = in_item.is_none ? 24'd0 : {in_item.red, in_item.green, in_item.blue};
    case (cpp)
      3'd1: nj.mask = 32'h0000_00FF;
      3'd2: nj.mask = 32'h0000_FFFF;
      3'd3: nj.mask = 32'h00FF_FFFF;
      default: nj.mask = 32'hFFFF_FFFF;
    endcase
    nj.symbol = (in_item.operation == OpDefine) ? in_item.symbol : (sym & nj.mask);
    nj.row_end = ({1'b0, column_count} + 17'd1) >= {1'b0, width};
    push = take && (nj.is_start || nj.is_define ||
                    (in_item.operation == OpPixel && done));
  end

  // Character gathering and column tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_buffer <= '0;
      char_position <= '0;
      column_count <= '0;
    end else if (take) begin
      if (in_item.operation == OpStart) begin
        char_buffer <= '0;
        char_position <= '0;
        column_count <= '0;
      end else if (in_item.operation == OpPixel) begin
        if (done) begin
          char_buffer <= '0;
          char_position <= '0;
          column_count <= nj.row_end ? 16'd0 : column_count + 16'd1;
        end else begin
          char_buffer <= sym[23:0];
          char_position <= char_position + 2'd1;
        end
      end
    end
  end

  // Queue occupancy and storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      q_count <= q_count + {1'b0, push} - {1'b0, q_rd};
    end
  end

  // A push never meets a full queue, since in_ready is low then.
  always_ff @(posedge clk) begin
    if (q_rd) begin
      q[0] <= (push && q_count == 2'd1) ? nj : q[1];
    end else if (push) begin
      if (q_count == 2'd0) q[0] <= nj;
      else q[1] <= nj;
    end
  end
endmodule

### hw/rtl/xpsd_lookup.sv
module xpsd_lookup (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  xpsd_pkg::job_t job,
  output logic out_valid,
  input  logic out_ready,
  output xpsd_pkg::out_item_t out_item
);
  import xpsd_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [31:0] symbol_mem [TableDepth];
  logic [23:0] color_mem [TableDepth];
  logic [CntW-1:0] entry_count;
  logic [IdxW-1:0] current_index;
  logic [1:0] state;
  logic [CntW-1:0] scan;
  logic [31:0] rd_sym;
  logic [23:0] rd_col;
  logic rd_ok;
  logic [IdxW-1:0] rd_idx;
  logic [31:0] mask;
  logic [31:0] key;
  logic row_end;
  logic hit;
  logic found_r;
  logic out_free;
  logic emit;

  assign job_ready = (state == StIdle);

  // One table entry read per cycle; the scan compares the registered word.
  always_ff @(posedge clk) begin
    rd_sym <= symbol_mem[scan[IdxW-1:0]];
    rd_col <= color_mem[scan[IdxW-1:0]];
    rd_idx <= scan[IdxW-1:0];
    if (job_valid && job_ready && job.is_define && entry_count < CntW'(TableDepth)) begin
      symbol_mem[entry_count[IdxW-1:0]] <= job.symbol;
      color_mem[entry_count[IdxW-1:0]] <= job.color;
    end
  end

  assign hit = rd_ok && ((rd_sym & mask) == key);
  assign out_free = !out_valid || out_ready;
  assign emit = out_free && (((state == StScan) && hit) || (state == StDone));

  // Result register: a new result loads only once the previous one has left.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      entry_count <= '0;
      current_index <= '0;
      scan <= '0;
      rd_ok <= 1'b0;
    end else begin
      case (state)
        StIdle: begin
          rd_ok <= 1'b0;
          if (job_valid && job_ready) begin
            if (job.is_start) begin
              entry_count <= '0;
              current_index <= '0;
            end else if (job.is_define) begin
              if (entry_count < CntW'(TableDepth)) entry_count <= entry_count + 1'b1;
            end else begin
              key <= job.symbol;
              mask <= job.mask;
              row_end <= job.row_end;
              scan <= '0;
              state <= StScan;
            end
          end
        end
        StScan: begin
          // rd_* holds entry scan-1 when rd_ok is set.
          if (hit && out_free) begin
            current_index <= rd_idx;
            out_item.palette_index <= 8'(rd_idx);
            {out_item.out_red, out_item.out_green, out_item.out_blue} <= rd_col;
            out_item.found <= 1'b1;
            out_item.row_end <= row_end;
            state <= StIdle;
          end else if (hit) begin
            // The output is still occupied, so the match is reported from StDone.
            current_index <= rd_idx;
            scan <= {1'b0, rd_idx};
            found_r <= 1'b1;
            rd_ok <= 1'b0;
            state <= StRead;
          end else if (scan >= entry_count) begin
            scan <= {1'b0, current_index};
            found_r <= 1'b0;
            rd_ok <= 1'b0;
            state <= StRead;
          end else begin
            rd_ok <= 1'b1;
            scan <= scan + 1'b1;
          end
        end
        StRead: state <= StDone;
        StDone: begin
          if (out_free) begin
            out_item.palette_index <= 8'(current_index);
            {out_item.out_red, out_item.out_green, out_item.out_blue} <=
              ({1'b0, current_index} < entry_count) ? rd_col : 24'd0;
            out_item.found <= found_r;
            out_item.row_end <= row_end;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

### hw/rtl/xpm_pixel_symbol_decoder.sv
// XPM pixel symbol decoder. Define transactions append palette entries (up to 256,
// later ones are dropped), pixel-character transactions are gathered chars_per_pixel
// at a time, and each completed symbol produces one result with its palette index,
// color, found flag and row-end mark; a start transaction clears the palette. A front
// end takes one character per cycle into a two-entry job queue and stalls its input
// only when that queue is full. The lookup engine scans the table one entry per cycle
// through its read port: when entry i is the lowest match and the output is free, the
// result is loaded straight from the scan state. A miss, or a hit that finds the
// output still occupied, passes through StRead and StDone before its result is loaded.
// The engine takes its next job only in StIdle, once the last one is finished, and
// define and start transactions are taken there too.
module xpm_pixel_symbol_decoder (
  input  logic clk,
  input  logic rst,
  xpsd_stream_if.sink in_ch,
  xpsd_stream_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import xpsd_pkg::*;

  logic [2:0] chars_per_pixel;
  logic [15:0] image_width;
  logic job_valid;
  logic job_ready;
  job_t job;
  in_item_t in_item;
  out_item_t out_item;

  assign pready = 1'b1;
  assign in_item = in_ch.data;
  assign out_ch.data = out_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_per_pixel <= 3'd1;
      image_width <= 16'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegCpp[0]: chars_per_pixel <= pwdata[2:0];
        RegWidth[0]: image_width <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegCpp[0]: prdata = {29'd0, chars_per_pixel};
      default: prdata = {16'd0, image_width};
    endcase
  end

  xpsd_front u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item,
    .chars_per_pixel, .image_width,
    .job_valid, .job_ready, .job
  );

  xpsd_lookup u_lookup (
    .clk, .rst,
    .job_valid, .job_ready, .job,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item
  );

  // A queued job and a waiting result both stay put until they are taken.
  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid) else $error("job dropped");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_item))
    else $error("result changed while stalled");
endmodule
